// ===== rtl/swf_pkg.sv =====
// Shared types and constants of the sliding window framer.
// No dependencies; imported by the core, swf_ctrl and swf_emit.
package swf_pkg;

	localparam int DATA_W      = 32;
	localparam int POS_W       = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int WLEN_W      = 7;
	localparam int HOP_W       = 16;
	localparam int OUT_DEPTH   = 4;
	localparam int OUT_PTR_W   = 2;
	localparam int OUT_CNT_W   = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOP        = 2'd1;

	localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd64;
	localparam logic [HOP_W-1:0]  HOP_RESET  = 16'd1;

	// metadata travelling alongside a store read
	typedef struct packed {
		logic             vld;
		logic [POS_W-1:0] position;
		logic             last;
	} rd_meta_t;

endpackage

// ===== rtl/sliding_window_framer_core.sv =====
// Sliding window framer: every accepted word is written into a circular
// store of WINDOW_MAX entries. A word that does not complete a publication
// leaves the framer ready for the next. When the window is full and hop new
// words have arrived, the window is read out oldest first, one store read
// per cycle while the output queue grants credit; no word is taken until
// the sweep ends. A four-word output queue lets results drain while the
// next word is taken. Depends on swf_pkg, swf_ctrl, swf_ram and swf_emit.
module sliding_window_framer_core import swf_pkg::*; #(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_W-1:0]     sample,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_W-1:0]     sample_res,
	output logic [POS_W-1:0]      position,
	output logic                  last
);

	localparam int PTR_W = WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1;

	rd_meta_t               meta_s1;
	logic                   can_issue;
	logic                   ram_we, ram_re;
	logic [PTR_W-1:0]       ram_waddr, ram_raddr;
	logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

	swf_ctrl #(
		.WINDOW_MAX (WINDOW_MAX),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample   (sample),
		.can_issue(can_issue),
		.meta_s1  (meta_s1),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr)
	);

	swf_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(WINDOW_MAX)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	swf_emit #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.meta_s1   (meta_s1),
		.rdata     (ram_rdata),
		.can_issue (can_issue),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample_res(sample_res),
		.position  (position),
		.last      (last)
	);

endmodule

// ===== rtl/swf_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module swf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/swf_emit.sv =====
// Output queue of the framer: takes store read data plus metadata, holds
// up to four words and grants read credit. Depends on swf_pkg.
module swf_emit import swf_pkg::*; #(
	parameter int SAMPLE_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rd_meta_t               meta_s1,
	input  logic [SAMPLE_BITS-1:0] rdata,
	output logic                   can_issue,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [DATA_W-1:0]      sample_res,
	output logic [POS_W-1:0]       position,
	output logic                   last
);

	logic [DATA_W-1:0]    data_q [OUT_DEPTH];
	logic [POS_W-1:0]     pos_q  [OUT_DEPTH];
	logic                 last_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OUT_CNT_W-1:0] cnt_q;
	logic                 push, pop;

	assign push      = meta_s1.vld;
	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign can_issue = (cnt_q + OUT_CNT_W'(meta_s1.vld)) < OUT_CNT_W'(OUT_DEPTH);

	assign sample_res = data_q[rd_ptr_q];
	assign position   = pos_q[rd_ptr_q];
	assign last       = last_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= DATA_W'(rdata);
			pos_q[wr_ptr_q]  <= meta_s1.position;
			last_q[wr_ptr_q] <= meta_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			cnt_q <= cnt_q + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
		end
	end

endmodule

// ===== rtl/swf_ctrl.sv =====
// Framer sequencer: config registers, write pointer, fill and step counters,
// and the read sweep over the window store. Depends on swf_pkg.
module swf_ctrl import swf_pkg::*; #(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [DATA_W-1:0]       sample,
	input  logic                    can_issue,
	output rd_meta_t                meta_s1,
	output logic                    ram_we,
	output logic [(WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1)-1:0] ram_waddr,
	output logic [SAMPLE_BITS-1:0]  ram_wdata,
	output logic                    ram_re,
	output logic [(WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1)-1:0] ram_raddr
);

	localparam int PTR_W = WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1;
	localparam int LEN_W = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W = LEN_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t            state_q;
	logic [WLEN_W-1:0] wlen_q;
	logic [HOP_W-1:0]  hop_q;
	logic [PTR_W-1:0]  wptr_q, wptr_nx;
	logic [PTR_W-1:0]  rptr_q;
	logic [LEN_W-1:0]  fill_q, fill_nx;
	logic [LEN_W-1:0]  k_q;
	logic [LEN_W-1:0]  len_eff;
	logic [HOP_W-1:0]  step_q, step_nx;
	logic [SUM_W-1:0]  start_sum, start_adj;
	logic              accept, publish, issue, k_last;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;

	always_comb begin
		if (wlen_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (wlen_q > WLEN_W'(WINDOW_MAX)) begin
			len_eff = LEN_W'(WINDOW_MAX);
		end else begin
			len_eff = LEN_W'(wlen_q);
		end
	end

	assign wptr_nx = (wptr_q == PTR_W'(WINDOW_MAX - 1)) ? '0 : wptr_q + PTR_W'(1);
	assign fill_nx = (fill_q < LEN_W'(WINDOW_MAX)) ? fill_q + LEN_W'(1) : fill_q;
	assign step_nx = (step_q != '1) ? step_q + HOP_W'(1) : step_q;
	assign publish = (fill_nx >= len_eff) && (step_nx >= hop_q);

	// oldest slot of the window, modulo the store depth
	assign start_sum = SUM_W'(wptr_nx) + SUM_W'(WINDOW_MAX) - SUM_W'(len_eff);
	assign start_adj = (start_sum >= SUM_W'(WINDOW_MAX)) ?
		start_sum - SUM_W'(WINDOW_MAX) : start_sum;

	assign issue  = (state_q == ST_READ) && can_issue;
	assign k_last = (k_q == len_eff - LEN_W'(1));

	assign ram_we    = accept;
	assign ram_waddr = wptr_q;
	assign ram_wdata = SAMPLE_BITS'(sample);
	assign ram_re    = issue;
	assign ram_raddr = rptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RESET;
			hop_q  <= HOP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_WINDOW_LEN) begin
				wlen_q <= cfg_data[WLEN_W-1:0];
			end else if (cfg_index == CFG_HOP) begin
				hop_q <= cfg_data[HOP_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			wptr_q           <= '0;
			rptr_q           <= '0;
			fill_q           <= '0;
			step_q           <= '0;
			k_q              <= '0;
			meta_s1.vld      <= 1'b0;
			meta_s1.position <= '0;
			meta_s1.last     <= 1'b0;
		end else begin
			meta_s1.vld <= issue;
			if (issue) begin
				meta_s1.position <= POS_W'(k_q);
				meta_s1.last     <= k_last;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						wptr_q <= wptr_nx;
						fill_q <= fill_nx;
						if (publish) begin
							step_q  <= '0;
							rptr_q  <= PTR_W'(start_adj);
							k_q     <= '0;
							state_q <= ST_READ;
						end else begin
							step_q <= step_nx;
						end
					end
				end
				ST_READ: begin
					if (issue) begin
						k_q    <= k_q + LEN_W'(1);
						rptr_q <= (rptr_q == PTR_W'(WINDOW_MAX - 1)) ?
							'0 : rptr_q + PTR_W'(1);
						if (k_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
